// ===== hw/rtl/czd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package czd_pkg;

	localparam int BYTE_W = 8;
	localparam int POS_W = 16;
	localparam int ZCNT_W = 4;
	localparam int NWR_W = 5;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [POS_W-1:0] HEADER_BYTES = 16'd5;
	localparam logic [POS_W-1:0] MAX_LEN_RESET = 16'd2048;

	// Code bytes of the encoding.
	localparam logic [BYTE_W-1:0] CODE_RAW = 8'hD0;
	localparam logic [BYTE_W-1:0] CODE_BAD_A = 8'hD1;
	localparam logic [BYTE_W-1:0] CODE_BAD_B = 8'hD2;
	localparam logic [BYTE_W-1:0] CODE_PAIR = 8'hE0;
	localparam logic [BYTE_W-1:0] CODE_BAD_C = 8'hFF;
	localparam logic [BYTE_W-1:0] RAW_RUN = 8'hCF;

	typedef enum logic [1:0] {
		STATUS_NONE = 2'd0,
		STATUS_DONE = 2'd1,
		STATUS_ERROR = 2'd2,
		STATUS_TIMEOUT = 2'd3
	} status_t;

	// One decoded input byte, as handed from the front end to the write sequencer.
	typedef struct packed {
		logic data_wr;
		logic [BYTE_W-1:0] data_val;
		logic [POS_W-1:0] base_pos;
		logic [NWR_W-1:0] n_writes;
		status_t status;
		logic [POS_W-1:0] flen;
	} job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/czd_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface czd_enc_if;
	logic valid;
	logic ready;
	logic no_byte;
	logic [czd_pkg::BYTE_W-1:0] rx_byte;

	modport source(output valid, no_byte, rx_byte, input ready);
	modport sink(input valid, no_byte, rx_byte, output ready);
endinterface

interface czd_dec_if;
	logic valid;
	logic ready;
	logic write_valid;
	logic [czd_pkg::POS_W-1:0] write_pos;
	logic [czd_pkg::BYTE_W-1:0] write_value;
	logic [1:0] status;
	logic [czd_pkg::POS_W-1:0] frame_length;
	logic last;

	modport source(output valid, write_valid, write_pos, write_value, status, frame_length,
		last, input ready);
	modport sink(input valid, write_valid, write_pos, write_value, status, frame_length,
		last, output ready);
endinterface

interface czd_cfg_if;
	logic valid;
	logic ready;
	logic [czd_pkg::POS_W-1:0] max_frame_len;

	modport source(output valid, max_frame_len, input ready);
	modport sink(input valid, max_frame_len, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/czd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module czd_front (
	input  logic           clk,
	input  logic           arst_n,
	czd_enc_if.sink        enc,
	czd_cfg_if.sink        cfg,
	input  logic           q_full,
	output logic           push,
	output czd_pkg::job_t  job
);

	logic                          in_frame_q, in_frame_n;
	logic                          length_known_q, length_known_n;
	logic                          len_fault_q, len_fault_n;
	logic [czd_pkg::POS_W-1:0]     total_len_q, total_len_n;
	logic [czd_pkg::POS_W-1:0]     write_index_q, write_index_n;
	logic [czd_pkg::BYTE_W-1:0]    data_left_q, data_left_n;
	logic [czd_pkg::ZCNT_W-1:0]    zeros_pending_q, zeros_pending_n;
	logic [czd_pkg::BYTE_W-1:0]    len_hi_q, len_hi_n;
	logic [czd_pkg::BYTE_W-1:0]    len_lo_q, len_lo_n;
	logic [czd_pkg::POS_W-1:0]     max_len_q;

	logic                          accept;
	logic [czd_pkg::POS_W:0]       len_sum;
	logic                          eval;
	logic                          len_over;
	logic                          len_ok;
	logic [czd_pkg::POS_W-1:0]     tl_eff;
	logic                          code_bad;
	logic [czd_pkg::BYTE_W-1:0]    code_dl;
	logic [czd_pkg::ZCNT_W-1:0]    code_z;
	logic                          mid;
	logic [czd_pkg::BYTE_W-1:0]    dl_dec;
	logic [czd_pkg::ZCNT_W-1:0]    zero_n;
	logic [czd_pkg::POS_W:0]       p0;
	logic [czd_pkg::POS_W:0]       pos_end;
	logic [czd_pkg::POS_W:0]       room;
	logic                          data_wr;
	logic [czd_pkg::ZCNT_W-1:0]    zcnt;
	logic                          step_err;
	logic                          done;

	assign enc.ready = !q_full;
	assign cfg.ready = 1'b1;
	assign accept = enc.valid && enc.ready;
	assign push = accept;

	// Length evaluation, code decode and write-count arithmetic for the current byte.
	always_comb begin
		len_sum = 17'(czd_pkg::HEADER_BYTES) + {1'b0, len_hi_q, len_lo_q};
		eval = (write_index_q >= 16'd2) && !length_known_q && !len_fault_q;
		len_over = eval && (len_sum > {1'b0, max_len_q});
		len_ok = eval && !len_over;
		tl_eff = len_ok ? len_sum[czd_pkg::POS_W-1:0] : total_len_q;

		code_bad = 1'b0;
		code_dl = '0;
		code_z = '0;
		if (enc.rx_byte < czd_pkg::CODE_RAW) begin
			code_dl = enc.rx_byte - 8'd1;
			code_z = 4'd1;
		end else if (enc.rx_byte == czd_pkg::CODE_RAW) begin
			code_dl = czd_pkg::RAW_RUN;
		end else if (enc.rx_byte == czd_pkg::CODE_BAD_A || enc.rx_byte == czd_pkg::CODE_BAD_B) begin
			code_bad = 1'b1;
		end else if (enc.rx_byte < czd_pkg::CODE_PAIR) begin
			code_z = 4'(enc.rx_byte - czd_pkg::CODE_RAW);
		end else if (enc.rx_byte < czd_pkg::CODE_BAD_C) begin
			code_dl = enc.rx_byte - czd_pkg::CODE_PAIR;
			code_z = 4'd2;
		end else begin
			code_bad = 1'b1;
		end

		mid = data_left_q != '0;
		dl_dec = data_left_q - 8'd1;
		if (mid) begin
			zero_n = (dl_dec == '0) ? zeros_pending_q : '0;
		end else begin
			zero_n = (code_dl == '0) ? code_z : '0;
		end

		p0 = {1'b0, write_index_q} + 17'(mid);
		pos_end = p0 + 17'(zero_n);
		data_wr = mid && (write_index_q < tl_eff);
		room = 17'(tl_eff) - p0;
		if (p0 >= 17'(tl_eff)) begin
			zcnt = '0;
		end else if (room > 17'(zero_n)) begin
			zcnt = zero_n;
		end else begin
			zcnt = room[czd_pkg::ZCNT_W-1:0];
		end

		step_err = len_fault_q || len_over || (!mid && code_bad);
		done = pos_end >= 17'(tl_eff);
	end

	// Next state and the job for the write sequencer.
	always_comb begin
		in_frame_n = in_frame_q;
		length_known_n = length_known_q;
		len_fault_n = len_fault_q;
		total_len_n = total_len_q;
		write_index_n = write_index_q;
		data_left_n = data_left_q;
		zeros_pending_n = zeros_pending_q;
		len_hi_n = len_hi_q;
		len_lo_n = len_lo_q;

		job.data_wr = 1'b0;
		job.data_val = enc.rx_byte;
		job.base_pos = '0;
		job.n_writes = '0;
		job.status = czd_pkg::STATUS_NONE;
		job.flen = '0;

		if (enc.no_byte) begin
			job.status = czd_pkg::STATUS_TIMEOUT;
		end else if (enc.rx_byte == '0) begin
			in_frame_n = 1'b1;
			length_known_n = 1'b0;
			len_fault_n = 1'b0;
			total_len_n = czd_pkg::HEADER_BYTES;
			write_index_n = '0;
			data_left_n = '0;
			zeros_pending_n = '0;
			len_hi_n = '0;
			len_lo_n = '0;
		end else if (in_frame_q) begin
			if (len_ok) begin
				total_len_n = tl_eff;
				length_known_n = 1'b1;
			end
			if (len_over) begin
				len_fault_n = 1'b1;
			end
			if (step_err) begin
				job.status = czd_pkg::STATUS_ERROR;
			end else begin
				if (mid) begin
					data_left_n = dl_dec;
					if (dl_dec == '0) begin
						zeros_pending_n = '0;
					end
				end else if (code_dl != '0) begin
					data_left_n = code_dl;
					zeros_pending_n = code_z;
				end

				write_index_n = pos_end[czd_pkg::POS_W] ? '1 : pos_end[czd_pkg::POS_W-1:0];

				// The length header lives at positions 0 and 1; track what lands there.
				if (data_wr && write_index_q == 16'd0) begin
					len_hi_n = enc.rx_byte;
				end
				if (data_wr && write_index_q == 16'd1) begin
					len_lo_n = enc.rx_byte;
				end
				if (p0 == 17'd0 && zcnt != '0) begin
					len_hi_n = '0;
				end
				if ((p0 == 17'd0 && zcnt >= 4'd2) || (p0 == 17'd1 && zcnt != '0)) begin
					len_lo_n = '0;
				end

				if (done) begin
					in_frame_n = 1'b0;
					job.status = czd_pkg::STATUS_DONE;
					job.flen = tl_eff;
				end

				job.data_wr = data_wr;
				job.base_pos = data_wr ? write_index_q : p0[czd_pkg::POS_W-1:0];
				job.n_writes = 5'(data_wr) + 5'(zcnt);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			length_known_q <= 1'b0;
			len_fault_q <= 1'b0;
			total_len_q <= czd_pkg::HEADER_BYTES;
			write_index_q <= '0;
			data_left_q <= '0;
			zeros_pending_q <= '0;
			len_hi_q <= '0;
			len_lo_q <= '0;
		end else if (accept) begin
			in_frame_q <= in_frame_n;
			length_known_q <= length_known_n;
			len_fault_q <= len_fault_n;
			total_len_q <= total_len_n;
			write_index_q <= write_index_n;
			data_left_q <= data_left_n;
			zeros_pending_q <= zeros_pending_n;
			len_hi_q <= len_hi_n;
			len_lo_q <= len_lo_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= czd_pkg::MAX_LEN_RESET;
		end else if (cfg.valid) begin
			max_len_q <= cfg.max_frame_len;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/czd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module czd_queue #(
	parameter int DEPTH = czd_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  czd_pkg::job_t  push_job,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output czd_pkg::job_t  head_job
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	czd_pkg::job_t     mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full = count_q == CNT_W'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/czd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module czd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  czd_pkg::job_t  head_job,
	output logic           pop,
	czd_dec_if.source      dec
);

	czd_pkg::job_t               job_q;
	logic                        busy_q;
	logic [czd_pkg::ZCNT_W-1:0]  idx_q;
	logic                        is_last;
	logic                        has_write;
	logic                        load;

	assign has_write = job_q.n_writes != '0;
	assign is_last = (5'(idx_q) + 5'd1) >= job_q.n_writes;
	assign load = !busy_q || (dec.ready && is_last);
	assign pop = head_valid && load;

	assign dec.valid = busy_q;
	assign dec.write_valid = has_write;
	assign dec.write_pos = has_write ? job_q.base_pos + 16'(idx_q) : '0;
	assign dec.write_value = (has_write && idx_q == '0 && job_q.data_wr) ? job_q.data_val : '0;
	assign dec.status = is_last ? job_q.status : czd_pkg::STATUS_NONE;
	assign dec.frame_length = is_last ? job_q.flen : '0;
	assign dec.last = is_last;

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			busy_q <= head_valid;
			idx_q <= '0;
		end else if (dec.ready) begin
			idx_q <= idx_q + 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_nowrite_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		dec.valid && !dec.write_valid |-> dec.last)
		else $error("result without a write is not the last of its byte");

	a_status_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		dec.valid && !dec.last |-> dec.status == czd_pkg::STATUS_NONE &&
			dec.frame_length == 16'd0)
		else $error("status or frame length shown before the last result");

	a_pos_steps: assert property (@(posedge clk) disable iff (!arst_n)
		dec.valid && dec.ready && !dec.last |=>
			dec.valid && dec.write_valid && dec.write_pos == 16'($past(dec.write_pos) + 16'd1))
		else $error("write position did not advance by one within a byte");

	a_pop_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !busy_q || (dec.valid && dec.ready && dec.last))
		else $error("job taken while the current one is still being written");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/cobs_zpe_zre_frame_decoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel | Role   | Transaction carries
// enc     | sink   | no_byte, rx_byte: one received encoded byte or a timeout
// dec     | source | write_valid, write_pos, write_value, status, frame_length, last
// cfg     | sink   | max_frame_len write, always ready
//
// The front end decodes one byte per cycle and queues a job for it while the queue has room.
// Each byte gives 1 to 15 results, one per cycle from the write sequencer while dec.ready
// is high; a byte without writes gives one, a data byte up to 3, the longest zero run 15.
// Reset clears the frame state and sets max_frame_len to 2048; no clearing pass is needed.
// A low dec.ready holds the current result; the QUEUE_DEPTH-entry job queue lets the front end
// keep taking bytes meanwhile, and enc.ready drops only when that queue is full.

module cobs_zpe_zre_frame_decoder_core #(
	parameter int QUEUE_DEPTH = czd_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	czd_enc_if.sink     enc,
	czd_dec_if.source   dec,
	czd_cfg_if.sink     cfg
);

	logic           q_full;
	logic           q_push;
	czd_pkg::job_t  q_push_job;
	logic           q_pop;
	logic           q_head_valid;
	czd_pkg::job_t  q_head_job;

	czd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.enc    (enc),
		.cfg    (cfg),
		.q_full (q_full),
		.push   (q_push),
		.job    (q_push_job)
	);

	czd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_job   (q_push_job),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_job   (q_head_job)
	);

	czd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head_job   (q_head_job),
		.pop        (q_pop),
		.dec        (dec)
	);

endmodule

`default_nettype wire

// ===== dv/tb_cobs_zpe_zre_frame_decoder_core.sv =====
`timescale 1ns / 1ps

module tb_cobs_zpe_zre_frame_decoder_core;
	import czd_pkg::*;

	localparam logic [7:0] FRAME_START = 8'h00;
	localparam logic [7:0] CODE_ONE_ZERO = 8'h01;
	localparam int unsigned PAIR_MAX = 30;
	localparam int unsigned RUN_MAX = 15;

	typedef struct packed {
		logic no_byte;
		logic [7:0] rx_byte;
	} enc_byte_t;

	typedef struct packed {
		logic write_valid;
		logic [15:0] write_pos;
		logic [7:0] write_value;
		status_t status;
		logic [15:0] frame_length;
		logic last;
	} dec_word_t;

	logic clk;
	logic arst_n;

	czd_enc_if enc_if();
	czd_dec_if dec_if();
	czd_cfg_if cfg_if();

	cobs_zpe_zre_frame_decoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.enc(enc_if),
		.dec(dec_if),
		.cfg(cfg_if)
	);

	enc_byte_t enc_bytes_q[$];
	dec_word_t decoded_q[$];
	dec_word_t step_writes[$];
	enc_byte_t next_byte;
	dec_word_t exp_word;

	int unsigned bytes_issued;
	int unsigned bytes_accepted;
	int unsigned mismatches;
	int unsigned gap_pct;
	int unsigned stall_pct;
	int unsigned gap_left;
	int unsigned stall_left;

	// Decoder state as the predictor sees it.
	logic pr_in_frame;
	logic pr_len_known;
	logic [15:0] pr_total_len;
	logic [15:0] pr_windex;
	logic [7:0] pr_data_left;
	logic [3:0] pr_zeros;
	logic [7:0] pr_len_hi;
	logic [7:0] pr_len_lo;
	logic pr_len_fault;
	logic [15:0] pr_max_len;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#15_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic int unsigned rand_gap();
		if ($urandom_range(0, 99) < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void clear_frame();
		pr_len_known = 1'b0;
		pr_total_len = HEADER_BYTES;
		pr_windex = '0;
		pr_data_left = '0;
		pr_zeros = '0;
		pr_len_hi = '0;
		pr_len_lo = '0;
		pr_len_fault = 1'b0;
	endfunction

	function automatic void put_write(int unsigned pos, logic [7:0] val);
		dec_word_t w;
		if (pos >= pr_total_len)
			return;
		w = '0;
		w.write_valid = 1'b1;
		w.write_pos = pos[15:0];
		w.write_value = val;
		w.status = STATUS_NONE;
		step_writes.push_back(w);
		if (pos == 0)
			pr_len_hi = val;
		else if (pos == 1)
			pr_len_lo = val;
	endfunction

	function automatic int unsigned put_zeros(int unsigned pos, int unsigned n);
		for (int unsigned i = 0; i < n; i++) begin
			put_write(pos, 8'h00);
			pos++;
		end
		return pos;
	endfunction

	// Works out the frame-buffer writes caused by one accepted byte.
	function automatic void decode_byte(logic nb, logic [7:0] b);
		status_t st;
		logic [15:0] flen;
		int unsigned pos;
		int unsigned dl;
		int unsigned z;
		int unsigned len_sum;
		bit err;
		dec_word_t w;
		st = STATUS_NONE;
		flen = '0;
		err = 1'b0;
		step_writes.delete();
		if (nb) begin
			st = STATUS_TIMEOUT;
		end else if (b == FRAME_START) begin
			pr_in_frame = 1'b1;
			clear_frame();
		end else if (pr_in_frame) begin
			if (pr_len_fault) begin
				err = 1'b1;
			end else if (pr_windex >= 2 && !pr_len_known) begin
				len_sum = 32'(HEADER_BYTES) + {pr_len_hi, pr_len_lo};
				if (len_sum > pr_max_len) begin
					pr_len_fault = 1'b1;
					err = 1'b1;
				end else begin
					pr_total_len = len_sum[15:0];
					pr_len_known = 1'b1;
				end
			end
			if (!err) begin
				pos = pr_windex;
				if (pr_data_left == 0) begin
					dl = 0;
					z = 0;
					if (b < CODE_RAW) begin
						dl = b - 1;
						z = 1;
					end else if (b == CODE_RAW) begin
						dl = RAW_RUN;
					end else if (b == CODE_BAD_A || b == CODE_BAD_B || b == CODE_BAD_C) begin
						err = 1'b1;
					end else if (b < CODE_PAIR) begin
						z = b - CODE_RAW;
					end else begin
						dl = b - CODE_PAIR;
						z = 2;
					end
					if (!err) begin
						if (dl == 0) begin
							pos = put_zeros(pos, z);
						end else begin
							pr_data_left = dl[7:0];
							pr_zeros = z[3:0];
						end
					end
				end else begin
					put_write(pos, b);
					pos++;
					pr_data_left = pr_data_left - 8'd1;
					if (pr_data_left == 0) begin
						pos = put_zeros(pos, pr_zeros);
						pr_zeros = '0;
					end
				end
				if (!err) begin
					if (pos >= pr_total_len) begin
						pr_in_frame = 1'b0;
						st = STATUS_DONE;
						flen = pr_total_len;
					end
					pr_windex = (pos > 32'hFFFF) ? 16'hFFFF : pos[15:0];
				end
			end
			if (err)
				st = STATUS_ERROR;
		end
		if (step_writes.size() == 0) begin
			w = '0;
			w.status = STATUS_NONE;
			step_writes.push_back(w);
		end
		step_writes[step_writes.size() - 1].status = st;
		step_writes[step_writes.size() - 1].frame_length = flen;
		step_writes[step_writes.size() - 1].last = 1'b1;
		foreach (step_writes[i])
			decoded_q.push_back(step_writes[i]);
	endfunction

	// Byte driver: a byte is offered until accepted, then an optional gap follows.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_if.valid <= 1'b0;
			enc_if.no_byte <= 1'b0;
			enc_if.rx_byte <= '0;
			gap_left <= 0;
		end else begin
			if (enc_if.valid && enc_if.ready) begin
				decode_byte(enc_if.no_byte, enc_if.rx_byte);
				bytes_accepted++;
			end
			if (!enc_if.valid || enc_if.ready) begin
				if (gap_left != 0) begin
					enc_if.valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (enc_bytes_q.size() != 0) begin
					next_byte = enc_bytes_q.pop_front();
					enc_if.valid <= 1'b1;
					enc_if.no_byte <= next_byte.no_byte;
					enc_if.rx_byte <= next_byte.rx_byte;
					if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
						gap_left <= rand_gap();
				end else begin
					enc_if.valid <= 1'b0;
				end
			end
		end
	end

	// Write monitor with random back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_if.ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (dec_if.valid && dec_if.ready) begin
				if (decoded_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected write transaction: wv=%0d pos=%0d val=%02h st=%0d len=%0d last=%0d",
							dec_if.write_valid, dec_if.write_pos, dec_if.write_value,
							dec_if.status, dec_if.frame_length, dec_if.last);
				end else begin
					exp_word = decoded_q.pop_front();
					if (dec_if.write_valid !== exp_word.write_valid ||
							dec_if.write_pos !== exp_word.write_pos ||
							dec_if.write_value !== exp_word.write_value ||
							dec_if.status !== exp_word.status ||
							dec_if.frame_length !== exp_word.frame_length ||
							dec_if.last !== exp_word.last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("Mismatch at %0t: exp wv=%0d pos=%0d val=%02h st=%0d len=%0d last=%0d",
								$time, exp_word.write_valid, exp_word.write_pos,
								exp_word.write_value, exp_word.status,
								exp_word.frame_length, exp_word.last);
							$display("                  got wv=%0d pos=%0d val=%02h st=%0d len=%0d last=%0d",
								dec_if.write_valid, dec_if.write_pos, dec_if.write_value,
								dec_if.status, dec_if.frame_length, dec_if.last);
						end
					end
				end
			end
			if (stall_left != 0) begin
				dec_if.ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				dec_if.ready <= 1'b0;
				stall_left <= rand_gap() - 1;
			end else begin
				dec_if.ready <= 1'b1;
			end
		end
	end

	task automatic push_byte(logic nb, logic [7:0] b);
		enc_byte_t e;
		e.no_byte = nb;
		e.rx_byte = b;
		enc_bytes_q.push_back(e);
		bytes_issued++;
	endtask

	function automatic logic [7:0] pick_bad_code();
		case ($urandom_range(0, 2))
			0: return CODE_BAD_A;
			1: return CODE_BAD_B;
			default: return CODE_BAD_C;
		endcase
	endfunction

	task automatic push_noise();
		case ($urandom_range(0, 2))
			0: push_byte(1'b1, 8'($urandom));
			1: push_byte(1'b0, 8'($urandom_range(0, 255)));
			default: push_byte(1'b0, pick_bad_code());
		endcase
	endtask

	// Payload length biased towards the limit: just inside, just over, or anywhere.
	function automatic int unsigned pick_len(logic [15:0] max_len);
		int unsigned room;
		int unsigned r;
		room = 32'(max_len) - 32'(HEADER_BYTES);
		r = $urandom_range(0, 99);
		if (r < 55)
			return $urandom_range(0, (room < 30) ? room : 30);
		if (r < 70 && room <= 240)
			return room;
		if (r < 85 && room <= 239)
			return room + 1;
		return $urandom_range(0, 65535);
	endfunction

	// Builds a decoded frame with the given payload length, encodes it and queues the bytes.
	// Very long frames are cut short; the next delimiter restarts the decoder anyway.
	task automatic queue_frame(int unsigned plen, bit dense);
		logic [7:0] fbuf[$];
		int unsigned n;
		int unsigned i;
		int unsigned k;
		int unsigned run;
		int unsigned r;
		n = 32'(HEADER_BYTES) + ((plen > 240) ? $urandom_range(0, 20) : plen);
		fbuf.push_back(plen[15:8]);
		fbuf.push_back(plen[7:0]);
		while (fbuf.size() < n) begin
			if (!dense && $urandom_range(0, 9) < 4) begin
				run = $urandom_range(1, 18);
				for (int unsigned j = 0; j < run && fbuf.size() < n; j++)
					fbuf.push_back(8'h00);
			end else begin
				run = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 35) : $urandom_range(1, 6);
				for (int unsigned j = 0; j < run && fbuf.size() < n; j++)
					fbuf.push_back(8'($urandom_range(1, 255)));
			end
		end
		push_byte(1'b0, FRAME_START);
		i = 0;
		while (i < n) begin
			r = $urandom_range(0, 99);
			if (r < 3)
				push_byte(1'b0, pick_bad_code());
			else if (r < 6)
				push_byte(1'b1, 8'($urandom));
			else if (r == 6)
				break;
			if (fbuf[i] == 0) begin
				run = 0;
				while (i + run < n && fbuf[i + run] == 0 && run < RUN_MAX)
					run++;
				if (run >= 3)
					push_byte(1'b0, CODE_RAW + 8'(run));
				else if (run == 2)
					push_byte(1'b0, CODE_PAIR);
				else
					push_byte(1'b0, CODE_ONE_ZERO);
				i += run;
			end else begin
				k = 0;
				while (i + k < n && fbuf[i + k] != 0 && k < RAW_RUN)
					k++;
				if (k == RAW_RUN) begin
					push_byte(1'b0, CODE_RAW);
					run = 0;
				end else if (k <= PAIR_MAX && i + k + 1 < n && fbuf[i + k + 1] == 0) begin
					push_byte(1'b0, CODE_PAIR + 8'(k));
					run = 2;
				end else begin
					push_byte(1'b0, CODE_ONE_ZERO + 8'(k));
					run = 1;
				end
				for (int unsigned j = 0; j < k; j++)
					push_byte(1'b0, fbuf[i + j]);
				i += k + run;
			end
		end
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (bytes_accepted != bytes_issued || decoded_q.size() != 0);
	endtask

	task automatic write_max_len(logic [15:0] v);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.max_frame_len <= v;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		pr_max_len = v;
		cfg_if.valid <= 1'b0;
	endtask

	task automatic run_phase(logic [15:0] max_len, int unsigned gap_p, int unsigned stall_p,
			int unsigned n_bytes, bit with_raw);
		int unsigned first;
		write_max_len(max_len);
		gap_pct = gap_p;
		stall_pct = stall_p;
		first = bytes_issued;
		if (with_raw)
			queue_frame(210, 1'b1);
		while (bytes_issued - first < n_bytes) begin
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 3)) push_noise();
			queue_frame(pick_len(max_len), 1'b0);
		end
		// The sender holds off here until every write of the phase has come back.
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_if.valid <= 1'b0;
		cfg_if.max_frame_len <= '0;
		bytes_issued = 0;
		bytes_accepted = 0;
		mismatches = 0;
		gap_pct = 20;
		stall_pct = 20;
		pr_in_frame = 1'b0;
		clear_frame();
		pr_max_len = MAX_LEN_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_byte(1'b0, 8'h11);
		push_byte(1'b1, FRAME_START);
		// A length of 65535 is over the limit, and the fault holds until the next delimiter.
		push_byte(1'b0, FRAME_START);
		push_byte(1'b0, CODE_ONE_ZERO + 8'd2);
		push_byte(1'b0, 8'hFF);
		push_byte(1'b0, 8'hFF);
		push_byte(1'b0, CODE_ONE_ZERO + 8'd4);
		push_byte(1'b0, CODE_ONE_ZERO + 8'd6);
		// Seven-byte frame: invalid code first, then a zero run overrunning the end.
		push_byte(1'b0, FRAME_START);
		push_byte(1'b0, CODE_BAD_C);
		push_byte(1'b0, CODE_ONE_ZERO);
		push_byte(1'b0, CODE_ONE_ZERO + 8'd2);
		push_byte(1'b0, 8'h02);
		push_byte(1'b0, 8'hFF);
		push_byte(1'b0, CODE_RAW + 8'd15);
		// 25-byte frame with a pair code, an invalid code mid-frame and the longest run.
		push_byte(1'b0, FRAME_START);
		push_byte(1'b0, CODE_ONE_ZERO);
		push_byte(1'b0, CODE_PAIR + 8'd2);
		push_byte(1'b0, 8'h14);
		push_byte(1'b0, 8'h80);
		push_byte(1'b0, CODE_BAD_A);
		push_byte(1'b0, CODE_RAW + 8'd15);
		push_byte(1'b0, CODE_RAW + 8'd3);
		push_byte(1'b0, CODE_ONE_ZERO + 8'd2);
		push_byte(1'b0, 8'h7F);
		push_byte(1'b0, 8'h01);
		wait_idle();

		run_phase(16'd5, 30, 30, 40, 1'b0);
		run_phase(16'hFFFF, 0, 0, 60, 1'b0);
		run_phase(MAX_LEN_RESET, 15, 10, 220, 1'b1);
		run_phase(16'($urandom_range(6, 40)), 50, 50, 40, 1'b0);

		repeat (32) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== cobs_zpe_zre_frame_decoder_core.f =====
hw/rtl/czd_pkg.sv
hw/rtl/czd_ifs.sv
hw/rtl/czd_front.sv
hw/rtl/czd_queue.sv
hw/rtl/czd_back.sv
hw/rtl/cobs_zpe_zre_frame_decoder_core.sv
dv/tb_cobs_zpe_zre_frame_decoder_core.sv
